/* rtl/core/sds_pkg.sv */
// ----------------------------------------------------------------------------
// sds_pkg
// Shared types and constants of the stepper dispense sequencer.
// ----------------------------------------------------------------------------
package sds_pkg;

    localparam int ACTION_W    = 2;
    localparam int SPEED_REQ_W = 16;
    localparam int CLOCK_W     = 28;
    localparam int STEPS_W     = 16;
    localparam int SPEED_W     = 10;
    localparam int DIVISOR_W   = SPEED_W + 1;
    localparam int PHASE_W     = 2;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = CLOCK_W;

    localparam logic [CLOCK_W-1:0]     CLOCK_RESET = 28'd128000000;
    localparam logic [STEPS_W-1:0]     STEPS_RESET = 16'd1600;
    localparam logic [SPEED_W-1:0]     SPEED_RESET = 10'd500;
    localparam logic [SPEED_W-1:0]     SPEED_MIN   = 10'd100;
    localparam logic [SPEED_W-1:0]     SPEED_MAX   = 10'd1000;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK     = 2'd0,
        ACT_DISPENSE = 2'd1,
        ACT_STOP     = 2'd2,
        ACT_BEAM     = 2'd3
    } action_t;

    localparam logic [PHASE_W-1:0] PH_IDLE = 2'd0;
    localparam logic [PHASE_W-1:0] PH_FWD  = 2'd1;
    localparam logic [PHASE_W-1:0] PH_REV  = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_TIMER_CLOCK = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MOVE_STEPS  = 1'b1;

    typedef struct packed {
        logic               step_out;
        logic               direction_out;
        logic               enable_n;
        logic               moving;
        logic [PHASE_W-1:0] cycle_phase;
        logic               request_pending;
    } result_t;

endpackage

/* rtl/core/sds_in_if.sv */
// ----------------------------------------------------------------------------
// sds_in_if
// Command channel: timer ticks, dispense, stop and beam-break transactions.
// ----------------------------------------------------------------------------
interface sds_in_if;

    logic                            valid;
    logic                            ready;
    logic [sds_pkg::ACTION_W-1:0]    action;
    logic [sds_pkg::SPEED_REQ_W-1:0] speed_request;

    modport source (output valid, output action, output speed_request, input ready);
    modport sink   (input valid, input action, input speed_request, output ready);

endinterface

/* rtl/core/sds_out_if.sv */
// ----------------------------------------------------------------------------
// sds_out_if
// Status channel: pin levels and cycle state after each command.
// ----------------------------------------------------------------------------
interface sds_out_if;

    logic                        valid;
    logic                        ready;
    logic                        step_out;
    logic                        direction_out;
    logic                        enable_n;
    logic                        moving;
    logic [sds_pkg::PHASE_W-1:0] cycle_phase;
    logic                        request_pending;

    modport source (output valid, output step_out, output direction_out, output enable_n,
                    output moving, output cycle_phase, output request_pending,
                    input ready);
    modport sink   (input valid, input step_out, input direction_out, input enable_n,
                    input moving, input cycle_phase, input request_pending,
                    output ready);

endinterface

/* rtl/core/sds_period_div.sv */
// ----------------------------------------------------------------------------
// sds_period_div
// Bit-serial restoring divider: half period = clock / (2 * speed) - 1,
// saturated, one quotient bit per cycle, then a final saturation step.
// ----------------------------------------------------------------------------
module sds_period_div #(
    parameter int PERIOD_WIDTH = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [sds_pkg::CLOCK_W-1:0]     dividend,
    input  logic [sds_pkg::SPEED_W-1:0]     speed,
    output logic                            busy,
    output logic [PERIOD_WIDTH-1:0]         half_period
);

    localparam int CLK_W = sds_pkg::CLOCK_W;
    localparam int DIV_W = sds_pkg::DIVISOR_W;
    localparam int CNT_W = $clog2(CLK_W + 1);
    localparam int QW    = (PERIOD_WIDTH > CLK_W) ? PERIOD_WIDTH : CLK_W;

    localparam longint unsigned MAX_L   = (64'd1 << PERIOD_WIDTH) - 64'd1;
    localparam longint unsigned RESET_Q =
        longint'(sds_pkg::CLOCK_RESET) / (2 * longint'(sds_pkg::SPEED_RESET));
    localparam longint unsigned RESET_H =
        (RESET_Q == 0) ? MAX_L : (((RESET_Q - 1) > MAX_L) ? MAX_L : (RESET_Q - 1));
    localparam logic [PERIOD_WIDTH-1:0] PERIOD_MAX = '1;

    logic                    busy_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [DIV_W-1:0]        rem_reg;
    logic [CLK_W-1:0]        quo_reg;
    logic [DIV_W-1:0]        divisor_reg;
    logic [PERIOD_WIDTH-1:0] half_reg;

    logic [DIV_W:0]          trial;
    logic                    fits;
    logic [DIV_W:0]          diff;
    logic [QW-1:0]           q_ext;
    logic [QW-1:0]           q_minus;
    logic [PERIOD_WIDTH-1:0] half_sat;

    // shift the next dividend bit into the partial remainder
    assign trial = {rem_reg, quo_reg[CLK_W-1]};
    assign fits  = (trial >= {1'b0, divisor_reg});
    assign diff  = trial - {1'b0, divisor_reg};

    assign q_ext   = QW'(quo_reg);
    assign q_minus = q_ext - QW'(1);
    assign half_sat = ((quo_reg == '0) || (q_minus > QW'(PERIOD_MAX)))
                      ? PERIOD_MAX : q_minus[PERIOD_WIDTH-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            half_reg <= PERIOD_WIDTH'(RESET_H);
        end
        else if (start)
        begin
            busy_reg    <= 1'b1;
            cnt_reg     <= CNT_W'(CLK_W);
            rem_reg     <= '0;
            quo_reg     <= dividend;
            divisor_reg <= {speed, 1'b0};
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                rem_reg <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
                quo_reg <= {quo_reg[CLK_W-2:0], fits};
            end
            else
            begin
                half_reg <= half_sat;
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy        = busy_reg;
    assign half_period = half_reg;

endmodule

/* rtl/core/sds_motion.sv */
// ----------------------------------------------------------------------------
// sds_motion
// Dispense cycle sequencer: step period counter, step pin, direction,
// step count and the stop, beam and request flags.
// ----------------------------------------------------------------------------
module sds_motion #(
    parameter int PERIOD_WIDTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  logic [sds_pkg::ACTION_W-1:0]      action,
    input  logic [sds_pkg::SPEED_REQ_W-1:0]   speed_request,
    input  logic [sds_pkg::STEPS_W-1:0]       move_steps,
    input  logic [PERIOD_WIDTH-1:0]           half_period,
    output logic                              div_start,
    output logic [sds_pkg::SPEED_W-1:0]       speed,
    output sds_pkg::result_t                  result_next
);

    localparam int SW = sds_pkg::STEPS_W;

    logic [sds_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic                        step_reg, step_next;
    logic                        dir_reg, dir_next;
    logic [SW-1:0]               steps_reg, steps_next;
    logic [PERIOD_WIDTH-1:0]     tick_reg, tick_next;
    logic [sds_pkg::SPEED_W-1:0] speed_reg, speed_next;
    logic                        stop_reg, stop_next;
    logic                        beam_reg, beam_next;
    logic                        pending_reg, pending_next;

    always_comb
    begin
        phase_next   = phase_reg;
        step_next    = step_reg;
        dir_next     = dir_reg;
        steps_next   = steps_reg;
        tick_next    = tick_reg;
        speed_next   = speed_reg;
        stop_next    = stop_reg;
        beam_next    = beam_reg;
        pending_next = pending_reg;
        div_start    = 1'b0;

        if (accept)
        begin
            // launch the forward move of a waiting request
            if (phase_reg == sds_pkg::PH_IDLE && pending_reg)
            begin
                pending_next = 1'b0;
                stop_next    = 1'b0;
                beam_next    = 1'b0;
                tick_next    = '0;
                dir_next     = 1'b1;
                steps_next   = move_steps;
                phase_next   = sds_pkg::PH_FWD;
                step_next    = 1'b0;
            end

            unique case (sds_pkg::action_t'(action))
                sds_pkg::ACT_TICK:
                begin
                    if (phase_next != sds_pkg::PH_IDLE)
                    begin
                        if (tick_next >= half_period)
                        begin
                            tick_next = '0;
                            priority if (stop_next || beam_next)
                            begin
                                phase_next = sds_pkg::PH_IDLE;
                            end
                            else if (steps_next == '0)
                            begin
                                if (phase_next == sds_pkg::PH_FWD)
                                begin
                                    dir_next   = 1'b0;
                                    steps_next = move_steps;
                                    phase_next = sds_pkg::PH_REV;
                                    step_next  = 1'b0;
                                end
                                else
                                begin
                                    phase_next = sds_pkg::PH_IDLE;
                                end
                            end
                            else if (!step_next)
                            begin
                                step_next = 1'b1;
                            end
                            else
                            begin
                                // falling edge completes one step
                                step_next  = 1'b0;
                                steps_next = steps_next - SW'(1);
                            end
                        end
                        else
                        begin
                            tick_next = tick_next + PERIOD_WIDTH'(1);
                        end
                    end
                end
                sds_pkg::ACT_DISPENSE:
                begin
                    priority if (speed_request < SPEED_REQ_W_MIN)
                        speed_next = sds_pkg::SPEED_MIN;
                    else if (speed_request > SPEED_REQ_W_MAX)
                        speed_next = sds_pkg::SPEED_MAX;
                    else
                        speed_next = speed_request[sds_pkg::SPEED_W-1:0];
                    tick_next    = '0;
                    pending_next = 1'b1;
                    div_start    = 1'b1;
                end
                sds_pkg::ACT_STOP:
                begin
                    stop_next = 1'b1;
                end
                sds_pkg::ACT_BEAM:
                begin
                    beam_next = 1'b1;
                end
            endcase
        end
    end

    localparam logic [sds_pkg::SPEED_REQ_W-1:0] SPEED_REQ_W_MIN =
        sds_pkg::SPEED_REQ_W'(sds_pkg::SPEED_MIN);
    localparam logic [sds_pkg::SPEED_REQ_W-1:0] SPEED_REQ_W_MAX =
        sds_pkg::SPEED_REQ_W'(sds_pkg::SPEED_MAX);

    always_comb
    begin
        result_next.step_out        = step_next;
        result_next.direction_out   = dir_next;
        result_next.enable_n        = (phase_next == sds_pkg::PH_IDLE);
        result_next.moving          = (phase_next != sds_pkg::PH_IDLE);
        result_next.cycle_phase     = phase_next;
        result_next.request_pending = pending_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= sds_pkg::PH_IDLE;
            step_reg    <= 1'b0;
            dir_reg     <= 1'b0;
            steps_reg   <= '0;
            tick_reg    <= '0;
            speed_reg   <= sds_pkg::SPEED_RESET;
            stop_reg    <= 1'b0;
            beam_reg    <= 1'b0;
            pending_reg <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            step_reg    <= step_next;
            dir_reg     <= dir_next;
            steps_reg   <= steps_next;
            tick_reg    <= tick_next;
            speed_reg   <= speed_next;
            stop_reg    <= stop_next;
            beam_reg    <= beam_next;
            pending_reg <= pending_next;
        end
    end

    assign speed = speed_next;

    a_tick_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tick_reg <= half_period)
        else $error("tick counter passed the half period");

    a_cycle_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept && phase_reg == sds_pkg::PH_IDLE && pending_reg
        |=> phase_reg != sds_pkg::PH_IDLE)
        else $error("pending request did not start a cycle");

    a_dispense_pending: assert property (@(posedge clk) disable iff (!rst_n)
        accept && action == sds_pkg::ACT_DISPENSE |=> pending_reg)
        else $error("dispense command did not latch a request");

endmodule

/* rtl/core/stepper_dispense_sequencer.sv */
// ----------------------------------------------------------------------------
// stepper_dispense_sequencer
// Step pulse generator for a forward/reverse dispense cycle.
// ----------------------------------------------------------------------------
// Each transaction's status is registered and presented in the cycle after it is accepted.
// Throughput: ticks, stops and beam breaks are taken one per cycle while the status sink keeps up and no divide runs.
// A dispense command, or a write of the timer clock register, holds off the command
// channel while the bit-serial divider (28 quotient bits plus a saturation step)
// recomputes the half period.
// Reset: all flags clear, cycle idle, config registers at their reset values; ready
// as soon as reset is released.
module stepper_dispense_sequencer #(
    parameter int PERIOD_WIDTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [sds_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [sds_pkg::CFG_DATA_W-1:0]    cfg_data,
    sds_in_if.sink                            item,
    sds_out_if.source                         result
);

    logic [sds_pkg::CLOCK_W-1:0] timer_clock_reg;
    logic [sds_pkg::STEPS_W-1:0] move_steps_reg;

    logic                        out_valid_reg;
    sds_pkg::result_t            out_reg;

    logic                        accept;
    logic                        div_busy;
    logic                        div_start;
    logic                        cmd_div_start;
    logic                        clock_write;
    logic [sds_pkg::CLOCK_W-1:0] div_dividend;
    logic [sds_pkg::SPEED_W-1:0] speed;
    logic [PERIOD_WIDTH-1:0]     half_period;
    sds_pkg::result_t            result_next;

    assign item.ready = !div_busy && (!out_valid_reg || result.ready);
    assign accept     = item.valid && item.ready;

    assign clock_write  = cfg_we && (cfg_index == sds_pkg::CFG_TIMER_CLOCK);
    assign div_start    = cmd_div_start || clock_write;
    assign div_dividend = clock_write ? cfg_data[sds_pkg::CLOCK_W-1:0] : timer_clock_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_clock_reg <= sds_pkg::CLOCK_RESET;
            move_steps_reg  <= sds_pkg::STEPS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sds_pkg::CFG_TIMER_CLOCK: timer_clock_reg <= cfg_data[sds_pkg::CLOCK_W-1:0];
                sds_pkg::CFG_MOVE_STEPS:  move_steps_reg  <= cfg_data[sds_pkg::STEPS_W-1:0];
                default:                  move_steps_reg  <= move_steps_reg;
            endcase
        end
    end

    sds_motion #(
        .PERIOD_WIDTH (PERIOD_WIDTH)
    ) u_motion (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .action        (item.action),
        .speed_request (item.speed_request),
        .move_steps    (move_steps_reg),
        .half_period   (half_period),
        .div_start     (cmd_div_start),
        .speed         (speed),
        .result_next   (result_next)
    );

    sds_period_div #(
        .PERIOD_WIDTH (PERIOD_WIDTH)
    ) u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (div_start),
        .dividend    (div_dividend),
        .speed       (speed),
        .busy        (div_busy),
        .half_period (half_period)
    );

    // output register: hold the status until the sink takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
            out_reg       <= result_next;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.step_out        = out_reg.step_out;
    assign result.direction_out   = out_reg.direction_out;
    assign result.enable_n        = out_reg.enable_n;
    assign result.moving          = out_reg.moving;
    assign result.cycle_phase     = out_reg.cycle_phase;
    assign result.request_pending = out_reg.request_pending;

    a_dispense_divides: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.action == sds_pkg::ACT_DISPENSE |=> div_busy && !item.ready)
        else $error("dispense command did not start a period update");

    a_period_steady: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(div_busy) && !div_busy |-> $stable(half_period))
        else $error("half period changed without a divide");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> !accept)
        else $error("transaction taken while the period divide runs");

endmodule
